/* hw/rtl/tcce_pkg.sv */
// Shared types and constants for the text console cursor engine.
// Holds the transaction payload structs, command codes, FSM states and control structs.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
    } tcce_in_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_entry;
        logic        scrolled;
    } tcce_out_t;

    typedef enum logic [1:0] {
        OP_PUT_CHAR   = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_READ_CELL  = 2'd3
    } tcce_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_FINISH
    } tcce_state_t;

    localparam logic [7:0]  CH_BS       = 8'd8;
    localparam logic [7:0]  CH_HT       = 8'd9;
    localparam logic [7:0]  CH_LF       = 8'd10;
    localparam logic [7:0]  CH_CR       = 8'd13;
    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [7:0]  RESET_ATTR  = 8'h0F;
    localparam logic [15:0] RESET_CELL  = {RESET_ATTR, BLANK_CHAR};

    typedef struct packed {
        logic capture;
        logic exec;
        logic cnt_clear;
        logic copy_step;
        logic fill_step;
        logic fill_init;
        logic grab_entry;
        logic out_load;
    } tcce_ctl_t;

    typedef struct packed {
        tcce_op_t op;
        logic     need_scroll;
        logic     cnt_end;
        logic     copy_end;
        logic     out_free;
    } tcce_stat_t;

endpackage

/* hw/rtl/tcce_ctrl.sv */
// Controller FSM for the text console cursor engine.
// Sequences execute, read, scroll, clear and reset sweeps; depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcce_pkg::tcce_stat_t stat,
    output tcce_pkg::tcce_ctl_t  ctl
);
    import tcce_pkg::*;

    tcce_state_t state_reg;
    tcce_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.fill_step = 1'b1;
                ctl.fill_init = 1'b1;
                if (stat.cnt_end)
                begin
                    ctl.cnt_clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (stat.op == OP_CLEAR)
                begin
                    ctl.cnt_clear = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else if (stat.op == OP_READ_CELL)
                begin
                    state_next = ST_READ;
                end
                else if (stat.need_scroll)
                begin
                    ctl.cnt_clear = 1'b1;
                    state_next    = ST_COPY;
                end
                else if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                ctl.grab_entry = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_COPY:
            begin
                ctl.copy_step = 1'b1;
                if (stat.copy_end)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK, ST_CLEAR:
            begin
                ctl.fill_step = 1'b1;
                if (stat.cnt_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

/* hw/rtl/tcce_datapath.sv */
// Datapath for the text console cursor engine: cell store, cursor, sweep counter,
// write stage and output register. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_datapath #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcce_pkg::tcce_in_t   in_data,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_data,
    input  tcce_pkg::tcce_ctl_t  ctl,
    output tcce_pkg::tcce_stat_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcce_pkg::tcce_out_t  out_data
);
    import tcce_pkg::*;

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int LAST  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(SCREEN_ROWS + 1);
    localparam int CW    = $clog2(SCREEN_COLUMNS + TAB_STOP);
    localparam int CIW   = $clog2(SCREEN_COLUMNS);

    logic [15:0]   cell_mem [CELLS];

    logic [7:0]    attr_reg;
    tcce_in_t      item_reg;
    logic [RW-1:0] row_reg,  row_next;
    logic [CW-1:0] col_reg,  col_next;
    logic [AW-1:0] cnt_reg,  cnt_next;
    logic          scrolled_reg, scrolled_next;
    logic [15:0]   entry_reg, entry_next;
    logic          w_en_reg, w_en_next;
    logic [AW-1:0] w_addr_reg, w_addr_next;
    logic [15:0]   w_data_reg, w_data_next;
    logic          w_from_rd_reg, w_from_rd_next;
    logic [15:0]   rd_data_reg;
    logic          out_valid_reg, out_valid_next;
    tcce_out_t     out_reg;

    logic [CW-1:0] tab_tbl [SCREEN_COLUMNS];

    tcce_op_t      op;
    logic          in_range;
    logic [RW-1:0] row_put, row_wrap;
    logic [CW-1:0] col_put, col_wrap, put_wcol;
    logic [7:0]    put_char;
    logic          put_we;
    logic          over;
    logic [AW-1:0] put_addr, read_addr, rd_addr;
    logic          rd_en;
    logic [RW+4:0] row_ext;
    logic [CW+6:0] col_ext;

    for (genvar g = 0; g < SCREEN_COLUMNS; g++)
    begin : g_tab
        assign tab_tbl[g] = CW'(g + TAB_STOP - (g % TAB_STOP));
    end

    assign op       = tcce_op_t'(item_reg.cmd);
    assign in_range = ({1'b0, item_reg.target_row} < 9'(SCREEN_ROWS)) &&
                      ({1'b0, item_reg.target_col} < 9'(SCREEN_COLUMNS));

    always_comb
    begin
        row_put  = row_reg;
        col_put  = col_reg + 1'b1;
        put_wcol = col_reg;
        put_char = item_reg.char_code;
        put_we   = 1'b1;
        unique case (item_reg.char_code)
            CH_LF:
            begin
                row_put = row_reg + 1'b1;
                col_put = '0;
                put_we  = 1'b0;
            end
            CH_CR:
            begin
                col_put = '0;
                put_we  = 1'b0;
            end
            CH_HT:
            begin
                col_put = tab_tbl[col_reg[CIW-1:0]];
                put_we  = 1'b0;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_put  = col_reg - 1'b1;
                    put_wcol = col_reg - 1'b1;
                    put_char = BLANK_CHAR;
                end
                else
                begin
                    col_put = col_reg;
                    put_we  = 1'b0;
                end
            end
            default:
            begin
                col_put = col_reg + 1'b1;
            end
        endcase

        if (col_put >= CW'(SCREEN_COLUMNS))
        begin
            col_wrap = '0;
            row_wrap = row_put + 1'b1;
        end
        else
        begin
            col_wrap = col_put;
            row_wrap = row_put;
        end
        over = (row_wrap >= RW'(SCREEN_ROWS));
    end

    assign put_addr  = AW'(row_reg) * AW'(SCREEN_COLUMNS) + AW'(put_wcol);
    assign read_addr = AW'(item_reg.target_row) * AW'(SCREEN_COLUMNS) +
                       AW'(item_reg.target_col);

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        scrolled_next = scrolled_reg;
        entry_next    = (ctl.grab_entry && in_range) ? rd_data_reg : entry_reg;
        if (ctl.exec)
        begin
            scrolled_next = 1'b0;
            entry_next    = '0;
            unique case (op)
                OP_PUT_CHAR:
                begin
                    if (over)
                    begin
                        row_next      = RW'(SCREEN_ROWS - 1);
                        col_next      = '0;
                        scrolled_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_wrap;
                        col_next = col_wrap;
                    end
                end
                OP_SET_CURSOR:
                begin
                    if (in_range)
                    begin
                        row_next = RW'(item_reg.target_row);
                        col_next = CW'(item_reg.target_col);
                    end
                end
                OP_CLEAR:
                begin
                    row_next = '0;
                    col_next = '0;
                end
                OP_READ_CELL:
                begin
                    row_next = row_reg;
                end
                default:
                begin
                    row_next = row_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        w_en_next      = 1'b0;
        w_addr_next    = cnt_reg;
        w_data_next    = ctl.fill_init ? RESET_CELL : {attr_reg, BLANK_CHAR};
        w_from_rd_next = 1'b0;
        if (ctl.copy_step)
        begin
            w_en_next      = 1'b1;
            w_from_rd_next = 1'b1;
        end
        else if (ctl.fill_step)
        begin
            w_en_next = 1'b1;
        end
        else if (ctl.exec && (op == OP_PUT_CHAR) && put_we)
        begin
            w_en_next   = 1'b1;
            w_addr_next = put_addr;
            w_data_next = {attr_reg, put_char};
        end
    end

    always_comb
    begin
        if (ctl.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (ctl.copy_step || ctl.fill_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    assign rd_en   = ctl.copy_step || (ctl.exec && (op == OP_READ_CELL) && in_range);
    assign rd_addr = ctl.copy_step ? cnt_reg + AW'(SCREEN_COLUMNS) : read_addr;

    assign out_valid_next = ctl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign row_ext = (RW + 5)'(row_next);
    assign col_ext = (CW + 7)'(col_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= RESET_ATTR;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            scrolled_reg  <= 1'b0;
            w_en_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            scrolled_reg  <= scrolled_next;
            w_en_reg      <= w_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg <= in_data;
        end
        entry_reg     <= entry_next;
        w_addr_reg    <= w_addr_next;
        w_data_reg    <= w_data_next;
        w_from_rd_reg <= w_from_rd_next;
        if (ctl.out_load)
        begin
            out_reg.cursor_row <= row_ext[4:0];
            out_reg.cursor_col <= col_ext[6:0];
            out_reg.cell_entry <= entry_next;
            out_reg.scrolled   <= scrolled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_en_reg)
        begin
            cell_mem[w_addr_reg] <= w_from_rd_reg ? rd_data_reg : w_data_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    assign stat.op          = op;
    assign stat.need_scroll = (op == OP_PUT_CHAR) && over;
    assign stat.cnt_end     = (cnt_reg == AW'(CELLS - 1));
    assign stat.copy_end    = (cnt_reg == AW'(LAST - 1));
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hw/rtl/text_console_cursor_engine_unit.sv */
// Top level of the text console cursor engine: controller plus datapath.
// Depends on tcce_pkg, tcce_ctrl and tcce_datapath.
`timescale 1ns / 1ps

// Character-cell text terminal with a cursor, one result transaction per command.
// The cell store is a single-port-write, single-port-read RAM of
// SCREEN_ROWS*SCREEN_COLUMNS 16-bit cells, and it sets the pace: after reset a clearing
// pass writes every cell once before the first command is taken. Configuration writes
// take effect at the next edge and belong between commands, while nothing is in flight.
// With the output register free, set cursor and a put character that does not scroll
// go from execute straight back to idle, and read cell goes through execute, read and
// finish. Clear screen and a put character that scrolls walk the store one cell per
// cycle. One command is in flight at a time; a finished result sits in the output
// register while the next command is taken, and a command that finishes while that
// register is still full holds until the waiting result is accepted.

module text_console_cursor_engine_unit #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_STOP       = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcce_pkg::tcce_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcce_pkg::tcce_out_t out_data,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data
);
    import tcce_pkg::*;

    tcce_ctl_t  ctl;
    tcce_stat_t stat;

    tcce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    tcce_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TAB_STOP       (TAB_STOP)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* hw/rtl/tcce_checker.sv */
// Port-level checks for the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine_unit.
`timescale 1ns / 1ps

module tcce_checker #(
    parameter int SCREEN_ROWS = 25
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tcce_pkg::tcce_out_t out_data
);
    import tcce_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while one is executing");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scrolled |->
            (out_data.cursor_col == 7'd0) && (out_data.cursor_row == 5'(SCREEN_ROWS - 1)))
        else $error("scroll did not leave cursor at start of last row");

    a_scroll_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scrolled |-> out_data.cell_entry == 16'd0)
        else $error("scrolling transaction carries a cell entry");

endmodule

bind text_console_cursor_engine_unit tcce_checker #(
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tcce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* test/tb_text_console_cursor_engine_unit.sv */
// Self-checking testbench for text_console_cursor_engine_unit: directed and random commands,
// a transaction-level screen/cursor predictor, random idling on both sides and output stalls.
// Depends on tcce_pkg and text_console_cursor_engine_unit.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_unit;

    import tcce_pkg::*;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int TAB_STOP       = 8;
    localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int IDLE_PERCENT   = 27;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 20_000_000;
    localparam int IN_BITS        = $bits(tcce_in_t);

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    tcce_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    tcce_out_t out_data;
    logic      cfg_write;
    logic [7:0] cfg_data;

    logic [15:0] screen_model [SCREEN_CELLS];
    int unsigned row_model;
    int unsigned col_model;
    logic [7:0]  attr_model;

    tcce_out_t expected_reports [$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        steady_flow;
    int        stall_request;

    text_console_cursor_engine_unit #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS),
        .TAB_STOP      (TAB_STOP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic tcce_in_t make_command(tcce_op_t op, logic [7:0] ch,
                                              logic [7:0] row, logic [7:0] col);
        tcce_in_t item;
        item.cmd        = op;
        item.char_code  = ch;
        item.target_row = row;
        item.target_col = col;
        return item;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < SCREEN_CELLS; i++)
            screen_model[i] = RESET_CELL;
        row_model  = 0;
        col_model  = 0;
        attr_model = RESET_ATTR;
    endfunction

    function automatic tcce_out_t apply_command(tcce_in_t item);
        tcce_out_t report;
        logic [15:0] blank;
        bit in_range;
        blank    = {attr_model, BLANK_CHAR};
        in_range = (item.target_row < SCREEN_ROWS) && (item.target_col < SCREEN_COLUMNS);
        report   = '0;
        case (item.cmd)
            OP_PUT_CHAR:
            begin
                case (item.char_code)
                    CH_LF:
                    begin
                        row_model++;
                        col_model = 0;
                    end
                    CH_CR:
                        col_model = 0;
                    CH_HT:
                        col_model = col_model + TAB_STOP - (col_model % TAB_STOP);
                    CH_BS:
                        if (col_model > 0)
                        begin
                            col_model--;
                            screen_model[row_model * SCREEN_COLUMNS + col_model] = blank;
                        end
                    default:
                    begin
                        screen_model[row_model * SCREEN_COLUMNS + col_model] =
                            {attr_model, item.char_code};
                        col_model++;
                    end
                endcase
                if (col_model >= SCREEN_COLUMNS)
                begin
                    col_model = 0;
                    row_model++;
                end
                if (row_model >= SCREEN_ROWS)
                begin
                    for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++)
                        screen_model[i] = screen_model[i + SCREEN_COLUMNS];
                    for (int i = (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i < SCREEN_CELLS; i++)
                        screen_model[i] = blank;
                    row_model       = SCREEN_ROWS - 1;
                    col_model       = 0;
                    report.scrolled = 1'b1;
                end
            end
            OP_SET_CURSOR:
                if (in_range)
                begin
                    row_model = 32'(item.target_row);
                    col_model = 32'(item.target_col);
                end
            OP_CLEAR:
            begin
                for (int i = 0; i < SCREEN_CELLS; i++)
                    screen_model[i] = blank;
                row_model = 0;
                col_model = 0;
            end
            default:
                if (in_range)
                    report.cell_entry =
                        screen_model[item.target_row * SCREEN_COLUMNS + item.target_col];
        endcase
        report.cursor_row = row_model[4:0];
        report.cursor_col = col_model[6:0];
        return report;
    endfunction

    function automatic tcce_in_t random_command();
        tcce_in_t item;
        int pick;
        int sub;
        item = tcce_in_t'(IN_BITS'($urandom));
        pick = $urandom_range(99);
        sub  = $urandom_range(99);
        if (pick < 70)
        begin
            item.cmd = OP_PUT_CHAR;
            if (sub < 5)
                item.char_code = CH_LF;
            else if (sub < 9)
                item.char_code = CH_CR;
            else if (sub < 15)
                item.char_code = CH_HT;
            else if (sub < 23)
                item.char_code = CH_BS;
        end
        else if (pick < 84)
        begin
            item.cmd = OP_SET_CURSOR;
            if (sub < 85)
            begin
                item.target_row = (sub < 30) ? 8'(SCREEN_ROWS - 1)
                                             : 8'($urandom_range(SCREEN_ROWS - 1));
                item.target_col = 8'($urandom_range(SCREEN_COLUMNS - 1));
            end
        end
        else if (pick < 98)
        begin
            item.cmd = OP_READ_CELL;
            if (sub < 50)
            begin
                item.target_row = 8'(row_model);
                item.target_col = 8'($urandom_range(SCREEN_COLUMNS - 1));
            end
            else if (sub < 90)
            begin
                item.target_row = 8'($urandom_range(SCREEN_ROWS - 1));
                item.target_col = 8'($urandom_range(SCREEN_COLUMNS - 1));
            end
        end
        else
            item.cmd = OP_CLEAR;
        return item;
    endfunction

    task automatic send_command(input tcce_in_t item);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        expected_reports.push_back(apply_command(item));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write  <= 1'b0;
        attr_model = value;
    endtask

    task automatic test_reset_screen();
        send_command(make_command(OP_READ_CELL, 8'h00, 8'd0, 8'd0));
        send_command(make_command(OP_READ_CELL, 8'hFF, 8'd24, 8'd79));
        send_command(make_command(OP_READ_CELL, 8'h00, 8'd25, 8'd0));
        send_command(make_command(OP_READ_CELL, 8'h00, 8'd0, 8'd80));
        send_command(make_command(OP_READ_CELL, 8'hFF, 8'd255, 8'd255));
        wait_idle();
    endtask

    task automatic test_control_codes();
        send_command(make_command(OP_PUT_CHAR, CH_BS, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, 8'h41, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, 8'h80, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(OP_PUT_CHAR, 8'h00, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, CH_HT, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, CH_BS, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, CH_CR, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, CH_LF, 8'd0, 8'd0));
        send_command(make_command(OP_READ_CELL, 8'h00, 8'd0, 8'd2));
        wait_idle();
    endtask

    task automatic test_cursor_and_scroll();
        send_command(make_command(OP_SET_CURSOR, 8'h00, 8'd25, 8'd0));
        send_command(make_command(OP_SET_CURSOR, 8'h00, 8'd0, 8'd80));
        send_command(make_command(OP_SET_CURSOR, 8'h00, 8'd24, 8'd79));
        send_command(make_command(OP_PUT_CHAR, 8'h5A, 8'd0, 8'd0));
        send_command(make_command(OP_READ_CELL, 8'h00, 8'd23, 8'd79));
        send_command(make_command(OP_SET_CURSOR, 8'h00, 8'd24, 8'd75));
        send_command(make_command(OP_PUT_CHAR, CH_HT, 8'd0, 8'd0));
        send_command(make_command(OP_PUT_CHAR, CH_LF, 8'd0, 8'd0));
        send_command(make_command(OP_CLEAR, 8'h00, 8'd0, 8'd0));
        send_command(make_command(OP_READ_CELL, 8'h00, 8'd12, 8'd40));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input bit no_idle);
        steady_flow = no_idle;
        repeat (count) send_command(random_command());
        wait_idle();
        steady_flow = 1'b0;
    endtask

    task automatic test_output_backpressure();
        stall_request = 400;
        repeat (16) send_command(random_command());
        wait_idle();
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_request) @(posedge clk);
                stall_request = 0;
            end
            else
                out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        tcce_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("unexpected result transaction: %p", out_data);
                error_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_data.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                           out_data.cursor_row);
                    error_count++;
                end
                if (out_data.cursor_col !== want.cursor_col)
                begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col,
                           out_data.cursor_col);
                    error_count++;
                end
                if (out_data.cell_entry !== want.cell_entry)
                begin
                    $error("cell_entry: expected %h, got %h", want.cell_entry,
                           out_data.cell_entry);
                    error_count++;
                end
                if (out_data.scrolled !== want.scrolled)
                begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled,
                           out_data.scrolled);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_write     = 1'b0;
        cfg_data      = '0;
        steady_flow   = 1'b0;
        stall_request = 0;
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_screen();
        write_attribute(8'hFF);
        test_control_codes();
        write_attribute(8'h00);
        test_cursor_and_scroll();
        write_attribute(8'($urandom));
        test_random_traffic(600, 1'b0);
        write_attribute(8'($urandom));
        test_random_traffic(600, 1'b1);
        test_output_backpressure();
        write_attribute(8'hA5);
        test_random_traffic(600, 1'b0);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
